// ----- src/hamming_ecc_128_byte_chunk_macros.svh -----
// assertion macros for the checker file
`ifndef HAMMING_ECC_128_BYTE_CHUNK_MACROS_SVH
`define HAMMING_ECC_128_BYTE_CHUNK_MACROS_SVH

// same-cycle implication, off during reset
`define HECC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("hecc assertion failed");

// next-cycle implication, off during reset
`define HECC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("hecc assertion failed");

`endif

// ----- src/hecc_pkg.sv -----
// types, constants and a parity function for the chunk hamming ecc block
package hecc_pkg;

	localparam int CHUNK_BYTES_DEF = 128;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 40;
	localparam int KIND_W     = 2;
	localparam int STATUS_W   = 2;

	// item kinds on the input side
	localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_GEN   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FIXED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FAIL  = 2'd2;

	localparam logic [6:0] START_COLUMN = 7'h77;
	localparam logic [6:0] START_LINE   = 7'h7F;
	localparam logic [6:0] COLUMN_MASK  = 7'h77;
	localparam logic [6:0] LINE_ALL     = 7'h7F;
	localparam logic [2:0] PAIR_ALL     = 3'h7;

	// bits of the byte feeding each column parity bit, bit 3 is never used
	localparam logic [7:0] COL_SEL [7] = '{8'h55, 8'h33, 8'h0F, 8'h00, 8'hAA, 8'hCC, 8'hF0};

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [7:0]          ecc_column;
		logic [7:0]          ecc_line_odd;
		logic [7:0]          ecc_line_even;
		logic [6:0]          fix_byte;
		logic [2:0]          fix_bit;
	} hecc_result_t;

	function automatic logic [6:0] column_bits(input logic [7:0] b);
		logic [6:0] m;
		m = '0;
		for (int i = 0; i < 7; i++) begin
			m[i] = ^(b & COL_SEL[i]);
		end
		return m;
	endfunction

endpackage

// ----- src/hamming_ecc_128_byte_chunk.sv -----
// top level of the chunk hamming ecc generator and checker
// Chunk hamming ECC, the three-byte code used on small-page flash cards, over up
// to CHUNK_BYTES bytes. Send the chunk's bytes as data items (tuser = data), then
// one end item: generate returns the three ecc bytes, check compares the stored
// ecc carried in tdata and returns ok, a single-bit fix (byte and bit to flip,
// with the repaired ecc) or failure. Either end item restarts the chunk;
// bytes past CHUNK_BYTES are dropped and kind 3 is ignored. One item is
// taken every cycle while the result side keeps up; an end item passes the
// input register, then the parity update and compare into the output
// register, from which its result is offered, and data items give no
// result. Back-pressure on the result side stalls the input register, and
// with it the input, only while the output register is still full.
module hamming_ecc_128_byte_chunk #(
	parameter int CHUNK_BYTES = hecc_pkg::CHUNK_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// data_byte [7:0], stored_column [15:8], stored_line_odd [23:16],
	// stored_line_even [31:24]
	input  logic [hecc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// kind [1:0]
	input  logic [hecc_pkg::KIND_W-1:0]     s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// ecc_column [7:0], ecc_line_odd [15:8], ecc_line_even [23:16],
	// fix_byte [30:24], fix_bit [33:31], zero [39:34]
	output logic [hecc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// status [1:0]
	output logic [hecc_pkg::STATUS_W-1:0]   m_axis_tuser
);
	import hecc_pkg::*;

	localparam int CNT_W = $clog2(CHUNK_BYTES + 1);

	// input register
	logic                    valid_s1;
	logic [KIND_W-1:0]       kind_s1;
	logic [IN_DATA_W-1:0]    data_s1;

	// chunk state
	logic [6:0]              column_acc_q;
	logic [6:0]              line_odd_acc_q;
	logic [6:0]              line_even_acc_q;
	logic [CNT_W-1:0]        byte_count_q;

	// output register
	logic                    out_valid_q;
	hecc_result_t            out_q;

	logic                    out_free;
	logic                    advance;
	logic                    has_room;
	logic [6:0]              idx;
	logic [7:0]              byte_s1;
	hecc_result_t            result;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	assign byte_s1  = data_s1[7:0];
	assign has_room = byte_count_q < CNT_W'(CHUNK_BYTES);
	// count stays below 128 while bytes are still taken
	assign idx      = 7'(byte_count_q);

	hecc_eval #(
		.CHUNK_BYTES(CHUNK_BYTES)
	) u_eval (
		.kind             (kind_s1),
		.column_acc       (column_acc_q),
		.line_odd_acc     (line_odd_acc_q),
		.line_even_acc    (line_even_acc_q),
		.byte_count       (byte_count_q),
		.stored_column    (data_s1[15:8]),
		.stored_line_odd  (data_s1[23:16]),
		.stored_line_even (data_s1[31:24]),
		.result           (result)
	);

	// input register: takes a new item whenever it is empty or the output register has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1 <= s_axis_tuser;
			data_s1 <= s_axis_tdata;
		end
	end

	// accumulators and byte count, updated as the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_acc_q    <= START_COLUMN;
			line_odd_acc_q  <= START_LINE;
			line_even_acc_q <= START_LINE;
			byte_count_q    <= '0;
		end else if (advance) begin
			unique case (kind_s1)
				KIND_DATA: begin
					if (has_room) begin
						column_acc_q <= column_acc_q ^ column_bits(byte_s1);
						if (^byte_s1) begin
							line_odd_acc_q  <= line_odd_acc_q ^ ~idx;
							line_even_acc_q <= line_even_acc_q ^ idx;
						end
						byte_count_q <= byte_count_q + CNT_W'(1);
					end
				end
				KIND_GEN, KIND_CHECK: begin
					column_acc_q    <= START_COLUMN;
					line_odd_acc_q  <= START_LINE;
					line_even_acc_q <= START_LINE;
					byte_count_q    <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// output register: loads on end items, empties when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && (kind_s1 == KIND_GEN || kind_s1 == KIND_CHECK)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (kind_s1 == KIND_GEN || kind_s1 == KIND_CHECK)) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {6'd0, out_q.fix_bit, out_q.fix_byte, out_q.ecc_line_even,
		out_q.ecc_line_odd, out_q.ecc_column};

endmodule

// ----- src/hecc_eval.sv -----
// end-of-chunk result: ecc output on generate, compare and locate on check
module hecc_eval #(
	parameter int CHUNK_BYTES = hecc_pkg::CHUNK_BYTES_DEF
) (
	input  logic [hecc_pkg::KIND_W-1:0]        kind,
	input  logic [6:0]                         column_acc,
	input  logic [6:0]                         line_odd_acc,
	input  logic [6:0]                         line_even_acc,
	input  logic [$clog2(CHUNK_BYTES+1)-1:0]   byte_count,
	input  logic [7:0]                         stored_column,
	input  logic [7:0]                         stored_line_odd,
	input  logic [7:0]                         stored_line_even,
	output hecc_pkg::hecc_result_t             result
);
	import hecc_pkg::*;

	logic [6:0] col_diff;
	logic [6:0] odd_diff;
	logic [6:0] even_diff;
	logic       any_diff;
	logic       single;

	assign col_diff  = (column_acc ^ stored_column[6:0]) & COLUMN_MASK;
	assign odd_diff  = line_odd_acc ^ stored_line_odd[6:0];
	assign even_diff = line_even_acc ^ stored_line_even[6:0];
	assign any_diff  = (col_diff != '0) || (odd_diff != '0) || (even_diff != '0);

	// complement-pair test plus position inside the received bytes
	assign single = ((odd_diff ^ even_diff) == LINE_ALL)
		&& ((col_diff[6:4] ^ col_diff[2:0]) == PAIR_ALL)
		&& (8'(even_diff) < 8'(byte_count));

	always_comb begin
		result = '0;
		if (kind == KIND_GEN) begin
			result.ecc_column    = {1'b0, column_acc};
			result.ecc_line_odd  = {1'b0, line_odd_acc};
			result.ecc_line_even = {1'b0, line_even_acc};
		end else begin
			result.ecc_column    = stored_column;
			result.ecc_line_odd  = stored_line_odd;
			result.ecc_line_even = stored_line_even;
			if (any_diff && single) begin
				result.status        = STATUS_FIXED;
				result.ecc_column    = {1'b0, stored_column[6:0] & COLUMN_MASK};
				result.ecc_line_odd  = {1'b0, stored_line_odd[6:0]};
				result.ecc_line_even = {1'b0, stored_line_even[6:0]};
				result.fix_byte      = even_diff;
				result.fix_bit       = col_diff[6:4];
			end else if (any_diff) begin
				result.status = STATUS_FAIL;
			end
		end
	end

endmodule

// ----- src/hecc_checker.sv -----
// port-level checks on the chunk hamming ecc block, bound to the top level
`include "hamming_ecc_128_byte_chunk_macros.svh"

module hecc_checker #(
	parameter int CHUNK_BYTES = hecc_pkg::CHUNK_BYTES_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [hecc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic [hecc_pkg::KIND_W-1:0]     s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [hecc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [hecc_pkg::STATUS_W-1:0]   m_axis_tuser
);
	import hecc_pkg::*;

	logic fixed;
	logic unused_in;

	assign fixed     = m_axis_tvalid && (m_axis_tuser == STATUS_FIXED);
	assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata) ^ (^s_axis_tuser);

	// a stalled result holds
	`HECC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// fix position only on a correction
	`HECC_ASSERT_NOW(a_fix_zero, clk, arst_n, m_axis_tvalid && !fixed,
		(m_axis_tdata[33:24] == 10'd0) && (unused_in || !unused_in))

	// a repaired ecc is masked
	`HECC_ASSERT_NOW(a_fix_masked, clk, arst_n, fixed,
		!m_axis_tdata[7] && !m_axis_tdata[3] && !m_axis_tdata[15] && !m_axis_tdata[23])

	// a corrected byte lies inside the chunk
	`HECC_ASSERT_NOW(a_fix_in_chunk, clk, arst_n, fixed,
		32'(m_axis_tdata[30:24]) < 32'(CHUNK_BYTES))

endmodule

bind hamming_ecc_128_byte_chunk hecc_checker #(
	.CHUNK_BYTES(CHUNK_BYTES)
) u_hecc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ----- tb/tb_hamming_ecc_128_byte_chunk.sv -----
// self-checking testbench for the chunk hamming ecc generator and checker
module tb_hamming_ecc_128_byte_chunk;
	timeunit 1ns;
	timeprecision 1ps;

	import hecc_pkg::*;

	localparam int CHUNK        = CHUNK_BYTES_DEF;
	localparam int LIMIT        = 200000;
	localparam int RANDOM_ITEMS = 600;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 8;

	// kind that the block drops without a result
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// how a chunk is closed by the stimulus
	typedef enum {
		END_GEN,
		END_CLEAN,
		END_DATA_FLIP,
		END_ECC_FLIP,
		END_DOUBLE_FLIP,
		END_PAST,
		END_RANDOM
	} chunk_end_t;

	// running parity of the chunk so far
	typedef struct packed {
		logic [6:0] col;
		logic [6:0] odd;
		logic [6:0] even;
		logic [7:0] count;
	} chunk_acc_t;

	typedef logic [7:0] byte_q_t[$];

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// data_byte [7:0], stored_column [15:8], stored_line_odd [23:16],
	// stored_line_even [31:24]
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	// kind [1:0]
	logic [KIND_W-1:0]     s_axis_tuser  = KIND_DATA;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// ecc_column [7:0], ecc_line_odd [15:8], ecc_line_even [23:16],
	// fix_byte [30:24], fix_bit [33:31]
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// status [1:0]
	logic [STATUS_W-1:0]   m_axis_tuser;

	bit idling_on = 1'b1;   // cleared for the last stretch of the run
	bit hold_req  = 1'b0;   // asks the result side for one long hold-off
	int counted   = 0;      // items that the block acts upon
	int cycles    = 0;

	// column parity bits of one byte, bit 3 is never used
	function automatic logic [6:0] byte_col_bits(input logic [7:0] b);
		return {^(b & 8'hF0), ^(b & 8'hCC), ^(b & 8'hAA), 1'b0,
			^(b & 8'h0F), ^(b & 8'h33), ^(b & 8'h55)};
	endfunction

	function automatic chunk_acc_t fresh_chunk();
		chunk_acc_t a;
		a.col   = START_COLUMN;
		a.odd   = START_LINE;
		a.even  = START_LINE;
		a.count = 8'd0;
		return a;
	endfunction

	// fold one data byte into the running parity, bytes past the chunk are dropped
	function automatic chunk_acc_t fold_byte(input chunk_acc_t a, input logic [7:0] b);
		chunk_acc_t r;
		r = a;
		if (a.count < CHUNK) begin
			r.col = a.col ^ byte_col_bits(b);
			// odd bytes mark their index in both line accumulators
			if (^b) begin
				r.odd  = a.odd ^ ~a.count[6:0];
				r.even = a.even ^ a.count[6:0];
			end
			r.count = a.count + 8'd1;
		end
		return r;
	endfunction

	// predicts the result of each end item and checks results in order
	class ecc_scoreboard;
		chunk_acc_t   acc;
		hecc_result_t awaited[$];
		int           errors;

		function new();
			acc = fresh_chunk();
			errors = 0;
		endfunction

		function void note_item(input logic [KIND_W-1:0] kind,
				input logic [IN_DATA_W-1:0] data);
			hecc_result_t r;
			logic [7:0]   sc, so, se;
			logic [6:0]   cd, od, ed;
			sc = data[15:8];
			so = data[23:16];
			se = data[31:24];
			r = '0;
			case (kind)
				KIND_DATA: acc = fold_byte(acc, data[7:0]);
				KIND_GEN: begin
					r.status        = STATUS_OK;
					r.ecc_column    = {1'b0, acc.col};
					r.ecc_line_odd  = {1'b0, acc.odd};
					r.ecc_line_even = {1'b0, acc.even};
					awaited.push_back(r);
					acc = fresh_chunk();
				end
				KIND_CHECK: begin
					cd = (acc.col ^ sc[6:0]) & COLUMN_MASK;
					od = acc.odd ^ so[6:0];
					ed = acc.even ^ se[6:0];
					r.status        = STATUS_OK;
					r.ecc_column    = sc;
					r.ecc_line_odd  = so;
					r.ecc_line_even = se;
					if (cd != '0 || od != '0 || ed != '0) begin
						// one flipped bit shows as complementary line and column halves
						if ((od ^ ed) == LINE_ALL && (cd[6:4] ^ cd[2:0]) == PAIR_ALL &&
								{1'b0, ed} < acc.count) begin
							r.status        = STATUS_FIXED;
							r.ecc_column    = sc & {1'b0, COLUMN_MASK};
							r.ecc_line_odd  = so & {1'b0, LINE_ALL};
							r.ecc_line_even = se & {1'b0, LINE_ALL};
							r.fix_byte      = ed;
							r.fix_bit       = cd[6:4];
						end else begin
							r.status = STATUS_FAIL;
						end
					end
					awaited.push_back(r);
					acc = fresh_chunk();
				end
				default: ;
			endcase
		endfunction

		function void compare_field(input string name, input int unsigned want,
				input int unsigned got);
			if (want != got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void match_result(input logic [OUT_DATA_W-1:0] data,
				input logic [STATUS_W-1:0] status);
			hecc_result_t want;
			if (awaited.size() == 0) begin
				$error("result item with nothing awaited");
				errors++;
				return;
			end
			want = awaited.pop_front();
			compare_field("status", want.status, status);
			compare_field("ecc_column", want.ecc_column, data[7:0]);
			compare_field("ecc_line_odd", want.ecc_line_odd, data[15:8]);
			compare_field("ecc_line_even", want.ecc_line_even, data[23:16]);
			compare_field("fix_byte", want.fix_byte, data[30:24]);
			compare_field("fix_bit", want.fix_bit, data[33:31]);
		endfunction
	endclass

	ecc_scoreboard sb = new();

	hamming_ecc_128_byte_chunk #(
		.CHUNK_BYTES(CHUNK)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// handshakes are sampled mid-cycle, where nothing is changing
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_item(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.match_result(m_axis_tdata, m_axis_tuser);
		end
	end

	// offer one item, sometimes after a random gap, and wait until it is taken
	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IN_DATA_W-1:0] data);
		int gap;
		bit taken;
		gap = (idling_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= data;
		do begin
			@(negedge clk);
			taken = s_axis_tready;
			@(posedge clk);
		end while (!taken);
	endtask

	function automatic byte_q_t random_bytes(input int n);
		byte_q_t q;
		for (int k = 0; k < n; k++)
			q.push_back(8'($urandom()));
		return q;
	endfunction

	// send a chunk and close it, with the stored ecc or the data damaged as asked
	task automatic send_chunk(input byte_q_t bytes, input chunk_end_t ending, input bit noisy);
		chunk_acc_t good;
		byte_q_t    sent;
		logic [7:0] sc, so, se;
		logic [6:0] p;
		logic [31:0] bits;
		logic [23:0] flip;
		int reach, i, j;
		good = fresh_chunk();
		foreach (bytes[k])
			good = fold_byte(good, bytes[k]);
		sent = bytes;
		reach = (bytes.size() < CHUNK) ? bytes.size() : CHUNK;
		// good code, with the bits that the compare masks off randomised
		bits = $urandom();
		sc = {bits[0], good.col[6:4], bits[1], good.col[2:0]};
		so = {bits[2], good.odd};
		se = {bits[3], good.even};
		case (ending)
			END_DATA_FLIP: begin
				if (reach > 0) begin
					i = $urandom_range(0, reach - 1);
					j = $urandom_range(0, 7);
					sent[i][j] = ~sent[i][j];
				end
			end
			END_DOUBLE_FLIP: begin
				for (int k = 0; k < 2; k++) begin
					if (reach > 0) begin
						i = $urandom_range(0, reach - 1);
						j = $urandom_range(0, 7);
						sent[i][j] = ~sent[i][j];
					end
				end
			end
			END_ECC_FLIP: begin
				flip = 24'd1 << $urandom_range(0, 23);
				{se, so, sc} = {se, so, sc} ^ flip;
			end
			END_PAST: begin
				// a well-formed single-bit pattern that points past the data
				if (reach < CHUNK) begin
					p = 7'($urandom_range(reach, CHUNK - 1));
					so = so ^ {1'b0, ~p};
					se = se ^ {1'b0, p};
					sc = sc ^ 8'h07;
				end
			end
			END_GEN, END_RANDOM: begin
				bits = $urandom();
				{se, so, sc} = bits[23:0];
			end
			default: ;
		endcase
		foreach (sent[k]) begin
			if (noisy && $urandom_range(0, 15) == 0)
				send_item(KIND_UNUSED, $urandom());
			bits = $urandom();
			send_item(KIND_DATA, {bits[31:8], sent[k]});
			if (k < CHUNK)
				counted++;
		end
		bits = $urandom();
		send_item((ending == END_GEN) ? KIND_GEN : KIND_CHECK, {se, so, sc, bits[7:0]});
		counted++;
	endtask

	// result side: random stalls, and one long hold-off when asked
	initial begin : result_side
		int stall_left;
		int run_left;
		stall_left = 0;
		run_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && run_left == 0) begin
				if (idling_on && $urandom_range(0, 3) == 0)
					stall_left = $urandom_range(1, 11);
				else
					run_left = $urandom_range(1, 24);
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if (run_left > 0)
					run_left--;
			end
		end
	end

	// hard stop on a hung run
	initial begin : watchdog
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		byte_q_t    corner;
		chunk_end_t ending;
		bit         hold_done;
		int         len;
		int         pick;
		corner = '{8'h00, 8'hFF, 8'h01, 8'h80};
		hold_done = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty chunks straight out of reset
		send_item(KIND_GEN, '0);
		send_item(KIND_CHECK, '0);
		// stored ecc differs only in the masked bits
		send_item(KIND_CHECK, '1);
		// extreme bytes: generate, clean check, single-bit repair, pointer past the data
		send_chunk(corner, END_GEN, 1'b0);
		send_chunk(corner, END_CLEAN, 1'b0);
		send_item(KIND_UNUSED, '1);
		send_chunk(corner, END_DATA_FLIP, 1'b0);
		send_chunk(corner, END_PAST, 1'b0);
		send_chunk(random_bytes(2), END_DOUBLE_FLIP, 1'b0);
		send_chunk(random_bytes(1), END_ECC_FLIP, 1'b0);

		// full and overfull chunks so the byte index reaches its top
		counted = 0;
		send_chunk(random_bytes(CHUNK), END_DATA_FLIP, 1'b1);
		send_chunk(random_bytes(CHUNK + 5), END_CLEAN, 1'b1);

		while (counted < RANDOM_ITEMS) begin
			if (!hold_done && counted > 300) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (counted > RANDOM_ITEMS * 9 / 10)
				idling_on = 1'b0;
			// mostly short chunks, now and then one around the chunk size
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(CHUNK - 8, CHUNK + 8) :
				$urandom_range(0, 24);
			pick = $urandom_range(0, 15);
			if (pick < 3)
				ending = END_GEN;
			else if (pick < 6)
				ending = END_CLEAN;
			else if (pick < 9)
				ending = END_DATA_FLIP;
			else if (pick < 11)
				ending = END_ECC_FLIP;
			else if (pick < 13)
				ending = END_DOUBLE_FLIP;
			else if (pick < 14)
				ending = END_PAST;
			else
				ending = END_RANDOM;
			send_chunk(random_bytes(len), ending, 1'b1);
		end
		s_axis_tvalid <= 1'b0;

		// drain the results still in flight
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
